### rtl/slu_pkg.sv
// Shared types, character constants and helper functions for the string
// literal unescaper. No dependencies.
package slu_pkg;

    // Parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_OPEN   = 5'b00001,
        PH_BODY   = 5'b00010,
        PH_ESC    = 5'b00100,
        PH_CODE   = 5'b01000,
        PH_CLOSED = 5'b10000
    } phase_t;

    // Fault held while a numeric code is still collecting digits.
    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_DIGIT = 2'd1,
        PEND_RANGE = 2'd2
    } pend_t;

    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_DQ    = 8'h22;  // '"'
    localparam logic [7:0] CH_BSL   = 8'h5C;  // backslash
    localparam logic [7:0] CH_X     = 8'h78;  // 'x'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    localparam logic [11:0] CODE_MAX  = 12'd255;
    localparam logic [1:0]  LEFT_OCT  = 2'd3;
    localparam logic [1:0]  LEFT_HEX  = 2'd2;
    localparam logic [4:0]  DIG_NONE  = 5'd16;
    localparam logic [4:0]  BASE_OCT  = 5'd8;
    localparam logic [4:0]  BASE_HEX  = 5'd16;

    // Digit value 0..15, or DIG_NONE when the character is no digit.
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] dv;
        dv = DIG_NONE;
        if (c >= 8'h30 && c <= 8'h39) begin
            dv = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            dv = 5'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            dv = 5'(c - 8'h41 + 8'd10);
        end
        return dv;
    endfunction

    // Standard C single-character escapes; anything else passes unchanged.
    function automatic logic [7:0] escape_map(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h6E:   r = 8'h0A;  // n
            8'h74:   r = 8'h09;  // t
            8'h72:   r = 8'h0D;  // r
            8'h61:   r = 8'h07;  // a
            8'h62:   r = 8'h08;  // b
            8'h66:   r = 8'h0C;  // f
            8'h76:   r = 8'h0B;  // v
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

### rtl/string_literal_unescape_core.sv
// String literal unescaper: input register, one-pass decode, result register.
// Depends on slu_pkg.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata/s_tlast) takes one raw
//   character per transfer; s_tlast marks the final character of a literal.
//   The first character is the opener ('<' closes with '>', '"' with '"').
//   The master channel (m_tvalid/m_tready/m_tdata/m_tlast) returns exactly
//   one result per input transfer, in order: a decoded byte with its valid
//   flag plus the error flags; m_tlast echoes the input's last flag.
//   A character accepted into the input register moves on through the
//   result register to the master side. Throughput: one character per
//   cycle while m_tready is high; the decode is a single combinational pass
//   over the parser state and the registered character, so nothing iterates.
//   Stall: while m_tready is low the result register holds; the input
//   register still takes one more character, then s_tready drops until the
//   result is taken. No transfer is lost or repeated.
//   Reset (aresetn low, synchronous): both stages empty, the parser waits
//   for an opener. After each last character the parser returns to that
//   same state for the next literal.
module string_literal_unescape_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] byte_valid, [8:1] out_byte, [9] err_incomplete, [10] err_bad_digit,
    // [11] err_code_range, [12] err_unterminated, [13] err_malformed,
    // [15:14] zero
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_last_reg;

    // Result stage
    logic        out_valid_reg;
    logic [13:0] out_data_reg;
    logic        out_last_reg;

    // Parser state
    slu_pkg::phase_t phase_reg, phase_next;
    logic            angle_reg, angle_next;
    logic            hex_reg, hex_next;
    logic [1:0]      left_reg, left_next;
    logic [7:0]      acc_reg, acc_next;
    slu_pkg::pend_t  pend_reg, pend_next;

    logic advance;  // input stage moves into the result stage
    logic [13:0] res_data;

    // Result fields
    logic       r_valid, r_inc, r_bad, r_range, r_unterm, r_mal;
    logic [7:0] r_byte;

    // Digit step operands
    logic            d_en, d_hex;
    logic [7:0]      d_acc;
    slu_pkg::pend_t  d_pend, d_pend2;
    logic [1:0]      d_left, d_left2;
    logic [4:0]      dv;
    logic [11:0]     d_val;
    logic [7:0]      d_acc2;
    logic [7:0]      closer;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};
    assign m_tlast  = out_last_reg;

    // Decode one character against the current parser state.
    always_comb begin
        phase_next = phase_reg;
        angle_next = angle_reg;
        hex_next   = hex_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        r_valid  = 1'b0;
        r_byte   = 8'h00;
        r_inc    = 1'b0;
        r_bad    = 1'b0;
        r_range  = 1'b0;
        r_unterm = 1'b0;
        r_mal    = 1'b0;
        d_en   = 1'b0;
        d_hex  = hex_reg;
        d_acc  = acc_reg;
        d_pend = pend_reg;
        d_left = left_reg;
        closer = angle_reg ? slu_pkg::CH_GT : slu_pkg::CH_DQ;

        unique case (phase_reg)
            slu_pkg::PH_OPEN: begin
                angle_next = (in_ch_reg == slu_pkg::CH_LT);
                r_mal = (in_ch_reg != slu_pkg::CH_LT) && (in_ch_reg != slu_pkg::CH_DQ);
                phase_next = slu_pkg::PH_BODY;
            end
            slu_pkg::PH_BODY: begin
                if (in_ch_reg == closer) begin
                    phase_next = slu_pkg::PH_CLOSED;
                end else if (in_ch_reg == slu_pkg::CH_BSL) begin
                    phase_next = slu_pkg::PH_ESC;
                end else begin
                    r_valid = 1'b1;
                    r_byte  = in_ch_reg;
                end
            end
            slu_pkg::PH_ESC: begin
                if (in_ch_reg >= slu_pkg::CH_ZERO && in_ch_reg <= slu_pkg::CH_NINE) begin
                    // Decimal digit opens an octal code and is its first digit.
                    d_en   = 1'b1;
                    d_hex  = 1'b0;
                    d_acc  = 8'h00;
                    d_pend = slu_pkg::PEND_NONE;
                    d_left = slu_pkg::LEFT_OCT;
                end else if (in_ch_reg == slu_pkg::CH_X) begin
                    hex_next   = 1'b1;
                    left_next  = slu_pkg::LEFT_HEX;
                    acc_next   = 8'h00;
                    pend_next  = slu_pkg::PEND_NONE;
                    phase_next = slu_pkg::PH_CODE;
                end else begin
                    r_valid    = 1'b1;
                    r_byte     = slu_pkg::escape_map(in_ch_reg);
                    phase_next = slu_pkg::PH_BODY;
                end
            end
            slu_pkg::PH_CODE: begin
                d_en = 1'b1;
            end
            slu_pkg::PH_CLOSED: begin
                r_mal = 1'b1;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        // One digit of a numeric code; keep only the first fault.
        dv      = slu_pkg::digit_of(in_ch_reg);
        d_val   = d_hex ? ({4'h0, d_acc} << 4) + {7'h00, dv}
                        : ({4'h0, d_acc} << 3) + {7'h00, dv};
        d_pend2 = d_pend;
        d_acc2  = d_acc;
        if (d_pend == slu_pkg::PEND_NONE) begin
            if (dv >= (d_hex ? slu_pkg::BASE_HEX : slu_pkg::BASE_OCT)) begin
                d_pend2 = slu_pkg::PEND_DIGIT;
            end else if (d_val > slu_pkg::CODE_MAX) begin
                d_pend2 = slu_pkg::PEND_RANGE;
            end else begin
                d_acc2 = d_val[7:0];
            end
        end
        d_left2 = d_left - 2'd1;

        if (d_en) begin
            hex_next  = d_hex;
            left_next = d_left2;
            if (d_left2 == 2'd0) begin
                // Final digit: emit the byte or report the held fault.
                r_bad      = (d_pend2 == slu_pkg::PEND_DIGIT);
                r_range    = (d_pend2 == slu_pkg::PEND_RANGE);
                r_valid    = (d_pend2 == slu_pkg::PEND_NONE);
                r_byte     = (d_pend2 == slu_pkg::PEND_NONE) ? d_acc2 : 8'h00;
                pend_next  = slu_pkg::PEND_NONE;
                acc_next   = 8'h00;
                phase_next = slu_pkg::PH_BODY;
            end else begin
                pend_next  = d_pend2;
                acc_next   = d_acc2;
                phase_next = slu_pkg::PH_CODE;
            end
        end

        // End of literal: flag what is still open, then return to reset state.
        if (in_last_reg) begin
            if (phase_next == slu_pkg::PH_ESC || phase_next == slu_pkg::PH_CODE) begin
                r_inc    = 1'b1;
                r_unterm = 1'b1;
            end else if (phase_next != slu_pkg::PH_CLOSED) begin
                r_unterm = 1'b1;
            end
            phase_next = slu_pkg::PH_OPEN;
            angle_next = 1'b0;
            hex_next   = 1'b0;
            left_next  = 2'd0;
            acc_next   = 8'h00;
            pend_next  = slu_pkg::PEND_NONE;
        end

        res_data = {r_mal, r_unterm, r_range, r_bad, r_inc, r_byte, r_valid};
    end

    // Control and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= slu_pkg::PH_OPEN;
            angle_reg     <= 1'b0;
            hex_reg       <= 1'b0;
            left_reg      <= 2'd0;
            acc_reg       <= 8'h00;
            pend_reg      <= slu_pkg::PEND_NONE;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                angle_reg     <= angle_next;
                hex_reg       <= hex_next;
                left_reg      <= left_next;
                acc_reg       <= acc_next;
                pend_reg      <= pend_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            out_data_reg <= res_data;
            out_last_reg <= in_last_reg;
        end
    end

    // Assertions
    a_inc_implies_unterm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9]) |-> (m_tdata[12] && m_tlast))
        else $error("incomplete code reported without unterminated end of literal");

    a_byte_excludes_faults: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> !(m_tdata[9] || m_tdata[10] || m_tdata[11] || m_tdata[13]))
        else $error("decoded byte emitted together with a code or framing fault");

    a_one_code_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[10] && m_tdata[11]))
        else $error("bad digit and range fault reported for the same code");

    a_last_resets_parser: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (phase_reg == slu_pkg::PH_OPEN && !angle_reg
                                      && pend_reg == slu_pkg::PEND_NONE))
        else $error("parser state not returned to opener after last character");

    a_code_has_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == slu_pkg::PH_CODE) |-> (left_reg != 2'd0))
        else $error("numeric code phase with no digits left");

endmodule

### verif/tb_string_literal_unescape_core.sv
`timescale 1ns / 100ps
// Self-checking bench for string_literal_unescape_core: a directed table, then random literals.
// A behavioral decoder predicts each result. Depends on slu_pkg and the core RTL.
module tb_string_literal_unescape_core;

    localparam int unsigned RANDOM_CHARS = 1050;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RUN_LIMIT_NS = 3_000_000;
    localparam int unsigned PRINT_LIMIT  = 30;

    // Result word exactly as it sits on m_tdata, lowest bit last.
    typedef struct packed {
        logic [1:0] pad;
        logic       err_malformed;
        logic       err_unterminated;
        logic       err_code_range;
        logic       err_bad_digit;
        logic       err_incomplete;
        logic [7:0] out_byte;
        logic       byte_valid;
    } unescape_res_t;

    // One predicted transfer on the master side: the result word plus tlast.
    typedef struct {
        unescape_res_t res;
        logic          done;
    } decoded_t;

    // One character to send; known marks a row whose result is typed in by hand.
    typedef struct {
        logic [7:0]    ch;
        logic          last;
        bit            known;
        unescape_res_t res;
    } stim_row_t;

    localparam unescape_res_t NO_RESULT = '0;
    localparam unescape_res_t F_INC     = 16'h0200;
    localparam unescape_res_t F_BAD     = 16'h0400;
    localparam unescape_res_t F_RNG     = 16'h0800;
    localparam unescape_res_t F_UNT     = 16'h1000;
    localparam unescape_res_t F_MAL     = 16'h2000;
    localparam string ESC_LETTERS = "ntrabfv";
    localparam string HEX_CHARS   = "0123456789abcdefABCDEF";

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // Predictor state, mirrors the parser after reset.
    slu_pkg::phase_t lit_phase    = slu_pkg::PH_OPEN;
    logic            closer_angle = 1'b0;
    logic            hex_code     = 1'b0;
    logic [1:0]      digits_left  = 2'd0;
    logic [7:0]      code_acc     = 8'd0;
    slu_pkg::pend_t  code_fault   = slu_pkg::PEND_NONE;

    decoded_t    pending_decodes[$];
    stim_row_t   directed_rows[$];
    stim_row_t   literal_chars[$];

    int unsigned in_gap_max    = 0;
    int unsigned out_stall_max = 0;
    int unsigned ready_hold    = 0;
    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned chars_sent = 0;
    int unsigned literals_sent = 0;
    int unsigned bytes_seen = 0;
    int unsigned faults_seen = 0;

    string_literal_unescape_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic unescape_res_t emits(input logic [7:0] b);
        return unescape_res_t'({7'd0, b, 1'b1});
    endfunction

    // Decode one character against the predictor state and advance that state.
    function automatic unescape_res_t decode_char(input logic [7:0] ch, input logic last);
        unescape_res_t r;
        logic [7:0]    closer;
        int unsigned   base;
        int unsigned   dv;
        int unsigned   acc;
        bit            feed;
        r = NO_RESULT;
        feed = 1'b0;
        closer = closer_angle ? slu_pkg::CH_GT : slu_pkg::CH_DQ;
        case (lit_phase)
            slu_pkg::PH_OPEN: begin
                // Anything but an angle falls back to a double-quote closer.
                closer_angle = (ch == slu_pkg::CH_LT);
                r.err_malformed = (ch != slu_pkg::CH_LT) && (ch != slu_pkg::CH_DQ);
                lit_phase = slu_pkg::PH_BODY;
            end
            slu_pkg::PH_BODY: begin
                if (ch == closer) begin
                    lit_phase = slu_pkg::PH_CLOSED;
                end else if (ch == slu_pkg::CH_BSL) begin
                    lit_phase = slu_pkg::PH_ESC;
                end else begin
                    r.byte_valid = 1'b1;
                    r.out_byte = ch;
                end
            end
            slu_pkg::PH_ESC: begin
                if (ch >= slu_pkg::CH_ZERO && ch <= slu_pkg::CH_NINE) begin
                    // A decimal digit opens an octal code and is its first digit.
                    hex_code = 1'b0;
                    digits_left = slu_pkg::LEFT_OCT;
                    code_acc = 8'd0;
                    code_fault = slu_pkg::PEND_NONE;
                    lit_phase = slu_pkg::PH_CODE;
                    feed = 1'b1;
                end else if (ch == slu_pkg::CH_X) begin
                    hex_code = 1'b1;
                    digits_left = slu_pkg::LEFT_HEX;
                    code_acc = 8'd0;
                    code_fault = slu_pkg::PEND_NONE;
                    lit_phase = slu_pkg::PH_CODE;
                end else begin
                    r.byte_valid = 1'b1;
                    lit_phase = slu_pkg::PH_BODY;
                    case (ch)
                        "n":     r.out_byte = 8'h0A;
                        "t":     r.out_byte = 8'h09;
                        "r":     r.out_byte = 8'h0D;
                        "a":     r.out_byte = 8'h07;
                        "b":     r.out_byte = 8'h08;
                        "f":     r.out_byte = 8'h0C;
                        "v":     r.out_byte = 8'h0B;
                        default: r.out_byte = ch;
                    endcase
                end
            end
            slu_pkg::PH_CODE: begin
                feed = 1'b1;
            end
            default: begin
                // Anything after the closer is flagged and dropped.
                r.err_malformed = 1'b1;
            end
        endcase

        if (feed) begin
            base = hex_code ? 16 : 8;
            // Keep only the first fault of a code.
            if (code_fault == slu_pkg::PEND_NONE) begin
                if (ch >= slu_pkg::CH_ZERO && ch <= slu_pkg::CH_NINE) begin
                    dv = ch - slu_pkg::CH_ZERO;
                end else if (ch >= "a" && ch <= "f") begin
                    dv = ch - "a" + 10;
                end else if (ch >= "A" && ch <= "F") begin
                    dv = ch - "A" + 10;
                end else begin
                    dv = 16;
                end
                acc = code_acc * base + dv;
                if (dv >= base) begin
                    code_fault = slu_pkg::PEND_DIGIT;
                end else if (acc > slu_pkg::CODE_MAX) begin
                    code_fault = slu_pkg::PEND_RANGE;
                end else begin
                    code_acc = 8'(acc);
                end
            end
            digits_left = digits_left - 2'd1;
            if (digits_left == 2'd0) begin
                r.err_bad_digit = (code_fault == slu_pkg::PEND_DIGIT);
                r.err_code_range = (code_fault == slu_pkg::PEND_RANGE);
                if (code_fault == slu_pkg::PEND_NONE) begin
                    r.byte_valid = 1'b1;
                    r.out_byte = code_acc;
                end
                code_fault = slu_pkg::PEND_NONE;
                code_acc = 8'd0;
                lit_phase = slu_pkg::PH_BODY;
            end
        end

        if (last) begin
            // Ending inside an escape drops any pending digit fault.
            if (lit_phase == slu_pkg::PH_ESC || lit_phase == slu_pkg::PH_CODE) begin
                r.err_incomplete = 1'b1;
                r.err_unterminated = 1'b1;
            end else if (lit_phase != slu_pkg::PH_CLOSED) begin
                r.err_unterminated = 1'b1;
            end
            lit_phase = slu_pkg::PH_OPEN;
            closer_angle = 1'b0;
            hex_code = 1'b0;
            digits_left = 2'd0;
            code_acc = 8'd0;
            code_fault = slu_pkg::PEND_NONE;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("MISMATCH at result %0d, %s: got 0x%0h, want 0x%0h",
                     results_checked, what, got_v, want_v);
        end
    endtask

    // Send one character: idle a random number of cycles, then hold valid until the
    // transfer, and queue the predicted result at the accepting edge.
    task automatic drive_char(input stim_row_t row);
        int unsigned   gap;
        unescape_res_t predicted;
        gap = $urandom_range(0, in_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.ch;
        s_tlast  <= row.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = decode_char(row.ch, row.last);
        pending_decodes.push_back('{row.known ? row.res : predicted, row.last});
        chars_sent++;
        if (row.last) literals_sent++;
    endtask

    function automatic void push_ch(input logic [7:0] c);
        literal_chars.push_back('{c, 1'b0, 1'b0, NO_RESULT});
    endfunction

    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 3);
        return (r == 0) ? 0 : (r == 1) ? 2 : 12;
    endfunction

    // Append random body tokens: plain characters, simple escapes, octal and hex codes.
    task automatic add_body_tokens(input logic [7:0] closer, input int unsigned count);
        int unsigned kind;
        int unsigned pick;
        int          i;
        logic [7:0]  c;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                // Keep plain characters from ending the literal early.
                c = 8'($urandom_range(0, 255));
                if (c == closer || c == slu_pkg::CH_BSL) c = ".";
                push_ch(c);
            end else if (kind < 6) begin
                // Mapped letters mostly; any byte otherwise, closer and digits included.
                push_ch(slu_pkg::CH_BSL);
                pick = $urandom_range(0, 9);
                push_ch(pick < 7 ? ESC_LETTERS[pick] : 8'($urandom_range(0, 255)));
            end else if (kind < 8) begin
                push_ch(slu_pkg::CH_BSL);
                for (i = 0; i < 3; i++) begin
                    // Favor a low lead digit so most codes fit in a byte.
                    if (i == 0 && $urandom_range(0, 3) != 0) begin
                        c = slu_pkg::CH_ZERO + 8'($urandom_range(0, 3));
                    end else begin
                        c = slu_pkg::CH_ZERO + 8'($urandom_range(0, 7));
                    end
                    if ($urandom_range(0, 11) == 0) begin
                        c = (i == 0) ? 8'("8" + $urandom_range(0, 1))
                                     : 8'($urandom_range(0, 255));
                    end
                    push_ch(c);
                end
            end else begin
                push_ch(slu_pkg::CH_BSL);
                push_ch(slu_pkg::CH_X);
                for (i = 0; i < 2; i++) begin
                    c = HEX_CHARS[$urandom_range(0, 21)];
                    if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
                    push_ch(c);
                end
            end
        end
    endtask

    // Build one random literal: mostly well formed, plus truncated ones, trailing
    // garbage after the closer, bad openers and pure noise.
    task automatic build_literal();
        int unsigned kind;
        int unsigned keep;
        logic [7:0]  opener;
        logic [7:0]  closer;
        literal_chars.delete();
        kind = $urandom_range(0, 99);
        opener = $urandom_range(0, 1) ? slu_pkg::CH_LT : slu_pkg::CH_DQ;
        if (kind >= 88 && kind < 94) begin
            opener = 8'($urandom_range(0, 255));
            if (opener == slu_pkg::CH_LT || opener == slu_pkg::CH_DQ) opener = "?";
        end
        closer = (opener == slu_pkg::CH_LT) ? slu_pkg::CH_GT : slu_pkg::CH_DQ;
        if (kind >= 94) begin
            repeat ($urandom_range(1, 6)) push_ch(8'($urandom_range(0, 255)));
        end else begin
            push_ch(opener);
            add_body_tokens(closer, $urandom_range(0, 8));
            push_ch(closer);
            if (kind >= 80 && kind < 88) begin
                repeat ($urandom_range(1, 3)) push_ch(8'($urandom_range(0, 255)));
            end
            if (kind >= 70 && kind < 80) begin
                // Cut before the closer, often inside an escape or code.
                keep = $urandom_range(1, literal_chars.size() - 1);
                while (literal_chars.size() > keep) void'(literal_chars.pop_back());
            end
        end
        literal_chars[literal_chars.size() - 1].last = 1'b1;
    endtask

    // Master side: after each transfer, hold ready low for a random stall.
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare every result transfer, field by field, with the oldest prediction.
    always @(posedge aclk) begin : result_check
        unescape_res_t got;
        decoded_t      want;
        if (aresetn && m_tvalid && m_tready) begin
            got = unescape_res_t'(m_tdata);
            ready_hold = $urandom_range(0, out_stall_max);
            if (pending_decodes.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata, 0);
            end else begin
                want = pending_decodes.pop_front();
                if (got.byte_valid !== want.res.byte_valid)
                    report_mismatch("byte_valid", got.byte_valid, want.res.byte_valid);
                if (got.out_byte !== want.res.out_byte)
                    report_mismatch("out_byte", got.out_byte, want.res.out_byte);
                if (got.err_incomplete !== want.res.err_incomplete)
                    report_mismatch("err_incomplete", got.err_incomplete,
                                    want.res.err_incomplete);
                if (got.err_bad_digit !== want.res.err_bad_digit)
                    report_mismatch("err_bad_digit", got.err_bad_digit, want.res.err_bad_digit);
                if (got.err_code_range !== want.res.err_code_range)
                    report_mismatch("err_code_range", got.err_code_range,
                                    want.res.err_code_range);
                if (got.err_unterminated !== want.res.err_unterminated)
                    report_mismatch("err_unterminated", got.err_unterminated,
                                    want.res.err_unterminated);
                if (got.err_malformed !== want.res.err_malformed)
                    report_mismatch("err_malformed", got.err_malformed, want.res.err_malformed);
                if (got.pad !== want.res.pad)
                    report_mismatch("pad bits", got.pad, want.res.pad);
                if (m_tlast !== want.done)
                    report_mismatch("tlast", m_tlast, want.done);
                if (want.res.byte_valid) bytes_seen++;
                if (want.res[13:9] != 5'd0) faults_seen++;
            end
            results_checked++;
        end
    end

    initial begin
        // Directed literals: rows with a typed result are checked against that
        // value; the rest against the predictor.
        directed_rows = '{
            '{slu_pkg::CH_DQ,  1'b0, 1'b1, NO_RESULT},       // double-quote opener
            '{8'h00,           1'b0, 1'b1, emits(8'h00)},    // lowest byte passes through
            '{slu_pkg::CH_BSL, 1'b0, 1'b1, NO_RESULT},
            '{"n",             1'b0, 1'b1, emits(8'h0A)},    // mapped escape
            '{slu_pkg::CH_BSL, 1'b0, 1'b0, NO_RESULT},
            '{slu_pkg::CH_DQ,  1'b0, 1'b0, NO_RESULT},       // closer taken as escaped char
            '{slu_pkg::CH_BSL, 1'b0, 1'b0, NO_RESULT},
            '{"1",             1'b0, 1'b0, NO_RESULT},
            '{"7",             1'b0, 1'b0, NO_RESULT},
            '{"7",             1'b0, 1'b1, emits(8'h7F)},    // octal 177
            '{slu_pkg::CH_BSL, 1'b0, 1'b0, NO_RESULT},
            '{slu_pkg::CH_X,   1'b0, 1'b0, NO_RESULT},
            '{"f",             1'b0, 1'b0, NO_RESULT},
            '{"F",             1'b0, 1'b1, emits(8'hFF)},    // hex ff, mixed case
            '{slu_pkg::CH_DQ,  1'b0, 1'b1, NO_RESULT},       // closer
            '{"z",             1'b1, 1'b1, F_MAL},           // trailing character
            '{slu_pkg::CH_LT,  1'b0, 1'b1, NO_RESULT},       // angle opener
            '{slu_pkg::CH_DQ,  1'b0, 1'b0, NO_RESULT},       // plain quote inside angles
            '{slu_pkg::CH_BSL, 1'b0, 1'b0, NO_RESULT},
            '{"9",             1'b0, 1'b0, NO_RESULT},       // octal lead digit out of base
            '{"0",             1'b0, 1'b0, NO_RESULT},
            '{"0",             1'b0, 1'b1, F_BAD},
            '{slu_pkg::CH_BSL, 1'b0, 1'b0, NO_RESULT},
            '{"4",             1'b0, 1'b0, NO_RESULT},
            '{"0",             1'b0, 1'b0, NO_RESULT},
            '{"0",             1'b0, 1'b1, F_RNG},           // octal 400 overflows a byte
            '{slu_pkg::CH_GT,  1'b1, 1'b1, NO_RESULT},       // clean end on the closer
            '{8'hFF,           1'b0, 1'b1, F_MAL},           // bad opener, highest byte
            '{slu_pkg::CH_BSL, 1'b1, 1'b1, F_INC | F_UNT}    // end right after a backslash
        };

        // Hold reset low, then release it on a falling edge.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        in_gap_max = 4;
        out_stall_max = 4;
        foreach (directed_rows[i]) drive_char(directed_rows[i]);

        // Random literals, with the idle pattern of each side redrawn per literal.
        while (chars_sent < directed_rows.size() + RANDOM_CHARS) begin
            in_gap_max = pick_idle();
            out_stall_max = pick_idle();
            build_literal();
            foreach (literal_chars[i]) drive_char(literal_chars[i]);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain: wait for every pending result, then keep watching for stray results.
        while (pending_decodes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d literals in %0d characters; %0d results checked.",
                 literals_sent, chars_sent, results_checked);
        $display("Results held %0d decoded bytes and %0d flagged faults; %0d mismatches.",
                 bytes_seen, faults_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("string_literal_unescape_core test passed");
        end else begin
            $display("string_literal_unescape_core test failed");
        end
        $finish;
    end

    // Watchdog: a stalled handshake ends the run as a failure.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results still pending", pending_decodes.size());
        $display("string_literal_unescape_core test failed");
        $finish;
    end

endmodule
